// ----- design/tfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller package
// Shared constants, codes and types for the fallback controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

  localparam int RING_DEPTH = 8;
  localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = $clog2(RING_DEPTH * 127 + 1);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_LOSS_TRG = 3'd2;
  localparam logic [2:0] REG_PROBE    = 3'd3;
  localparam logic [2:0] REG_RETRY    = 3'd4;
  localparam logic [2:0] REG_RECOVER  = 3'd5;

  localparam logic        RST_ENABLE   = 1'b1;
  localparam logic [19:0] RST_TIMEOUT  = 20'd5000;
  localparam logic [6:0]  RST_LOSS_TRG = 7'd50;
  localparam logic [19:0] RST_PROBE    = 20'd60000;
  localparam logic [7:0]  RST_RETRY    = 8'd3;
  localparam logic [6:0]  RST_RECOVER  = 7'd10;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_TIMEOUT = 3'd1;
  localparam logic [2:0] REQ_LOSS    = 3'd2;
  localparam logic [2:0] REQ_ICMP    = 3'd3;
  localparam logic [2:0] REQ_MANUAL  = 3'd4;
  localparam logic [2:0] REQ_CONNECT = 3'd5;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_TIMEOUT = 3'd2;
  localparam logic [2:0] OP_LOSS    = 3'd3;
  localparam logic [2:0] OP_ICMP    = 3'd4;
  localparam logic [2:0] OP_MANUAL  = 3'd5;
  localparam logic [2:0] OP_CONNECT = 3'd6;

  localparam logic [1:0] MODE_PRIMARY = 2'd0;
  localparam logic [1:0] MODE_FALLING = 2'd1;
  localparam logic [1:0] MODE_BACKUP  = 2'd2;

  localparam logic [2:0] WHY_NONE       = 3'd0;
  localparam logic [2:0] WHY_TIMEOUT    = 3'd1;
  localparam logic [2:0] WHY_UNREACH    = 3'd2;
  localparam logic [2:0] WHY_PROHIBITED = 3'd3;
  localparam logic [2:0] WHY_LOSS       = 3'd4;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_DISABLED = 2'd1;
  localparam logic [1:0] STS_BUSY     = 2'd2;

  localparam logic [7:0] ICMP_UNREACH_TYPE = 8'd3;
  localparam logic [7:0] ICMP_PORT_CODE    = 8'd3;
  localparam logic [7:0] ICMP_NET_PROHIB   = 8'd9;
  localparam logic [7:0] ICMP_HOST_PROHIB  = 8'd10;
  localparam logic [7:0] ICMP_ADMIN_PROHIB = 8'd13;

  localparam logic [20:0] ELAPSED_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic        enable;
    logic [19:0] timeout_limit;
    logic [6:0]  loss_trigger;
    logic [19:0] probe_interval;
    logic [7:0]  retry_limit;
    logic [6:0]  recover_below;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] loss;
    logic [2:0] why;
    logic       ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       started;
    logic       advises;
    logic       recovered;
    logic [1:0] mode;
    logic [2:0] cause;
    logic [6:0] avg;
    logic [7:0] attempts;
  } res_t;

endpackage

`default_nettype wire

// ----- design/tfc_front.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller front end
// Accepts requests, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [2:0]    req_type_i,
  input  wire logic [6:0]    loss_rate_i,
  input  wire logic [7:0]    icmp_type_i,
  input  wire logic [7:0]    icmp_code_i,
  input  wire logic [2:0]    trigger_reason_i,
  input  wire logic          connect_ok_i,
  output logic               cmd_valid_o,
  output tfc_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);
  import tfc_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_in;
  logic              do_push, do_pop;

  always_comb begin
    cmd_in.op   = OP_NONE;
    cmd_in.loss = loss_rate_i;
    cmd_in.why  = trigger_reason_i;
    cmd_in.ok   = connect_ok_i;
    case (req_type_i)
      REQ_TICK:    cmd_in.op = OP_TICK;
      REQ_TIMEOUT: cmd_in.op = OP_TIMEOUT;
      REQ_LOSS:    cmd_in.op = OP_LOSS;
      REQ_ICMP: begin
        if (icmp_type_i == ICMP_UNREACH_TYPE) begin
          if (icmp_code_i == ICMP_PORT_CODE) begin
            cmd_in.op  = OP_ICMP;
            cmd_in.why = WHY_UNREACH;
          end else if (icmp_code_i == ICMP_NET_PROHIB || icmp_code_i == ICMP_HOST_PROHIB ||
                       icmp_code_i == ICMP_ADMIN_PROHIB) begin
            cmd_in.op  = OP_ICMP;
            cmd_in.why = WHY_PROHIBITED;
          end
        end
      end
      REQ_MANUAL:  cmd_in.op = OP_MANUAL;
      REQ_CONNECT: cmd_in.op = OP_CONNECT;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/tfc_div.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller divider
// Serial restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [tfc_pkg::SUM_W-1:0] dividend_i,
  input  wire logic [tfc_pkg::CNT_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [tfc_pkg::SUM_W-1:0]      quotient_o
);
  import tfc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- design/tfc_back.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller back end
// Executes queued commands on the mode state and loss history, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tfc_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire tfc_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output tfc_pkg::res_t      res_o,
  input  wire logic          pop_i
);
  import tfc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOSS = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       started;
    logic [1:0] mode;
    logic [2:0] cause;
  } trig_t;

  function automatic trig_t try_trigger(input logic en, input logic [1:0] mode,
                                        input logic [2:0] cause, input logic [2:0] why);
    trig_t t;
    t.status  = STS_OK;
    t.started = 1'b0;
    t.mode    = mode;
    t.cause   = cause;
    if (!en) begin
      t.status = STS_DISABLED;
    end else if (mode == MODE_FALLING || mode == MODE_BACKUP) begin
      t.status = STS_BUSY;
    end else begin
      t.mode    = MODE_FALLING;
      t.cause   = why;
      t.started = 1'b1;
    end
    return t;
  endfunction

  logic [1:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [2:0]       cause_q, cause_d;
  logic [6:0]       ring_q [RING_DEPTH];
  logic [6:0]       ring_d [RING_DEPTH];
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [6:0]       avg_q, avg_d;
  logic [7:0]       att_q, att_d;
  logic [20:0]      elapsed_q, elapsed_d;
  logic [19:0]      cd_q, cd_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  logic             res_load, res_free;
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_quo;
  logic [19:0]      probe_load;

  assign res_free   = !res_valid_q || pop_i;
  assign probe_load = (cfg_i.probe_interval == '0) ? 20'd1 : cfg_i.probe_interval;

  tfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    trig_t      tr;
    logic [6:0] old;
    logic [19:0] cd_dec;
    logic [7:0] att_n;
    logic [1:0] status;
    logic       started;
    logic       advises;
    logic       recov;
    tr        = '0;
    old       = ring_q[pos_q];
    cd_dec    = cd_q - 1'b1;
    att_n     = att_q + {7'd0, (att_q != 8'hFF)};
    status    = STS_OK;
    started   = 1'b0;
    advises   = 1'b0;
    recov     = 1'b0;
    state_d   = state_q;
    mode_d    = mode_q;
    cause_d   = cause_q;
    ring_d    = ring_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    avg_d     = avg_q;
    att_d     = att_q;
    elapsed_d = elapsed_q;
    cd_d      = cd_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_LOSS) begin
            cmd_pop_o     = 1'b1;
            ring_d[pos_q] = cmd_i.loss;
            pos_d         = (pos_q == POS_W'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
            sum_d         = sum_q - SUM_W'(old) + SUM_W'(cmd_i.loss);
            cnt_d         = cnt_q - CNT_W'(old != '0) + CNT_W'(cmd_i.loss != '0);
            div_start     = 1'b1;
            state_d       = ST_DIV;
          end else if (res_free) begin
            cmd_pop_o = 1'b1;
            res_load  = 1'b1;
            case (cmd_i.op)
              OP_TICK: begin
                if (elapsed_q != ELAPSED_MAX) begin
                  elapsed_d = elapsed_q + 1'b1;
                end
                if (mode_q == MODE_BACKUP && cd_q != '0) begin
                  cd_d = cd_dec;
                  if (cd_dec == '0) begin
                    if (avg_q < cfg_i.recover_below) begin
                      mode_d  = MODE_PRIMARY;
                      cause_d = WHY_NONE;
                      recov   = 1'b1;
                    end else begin
                      cd_d = probe_load;
                    end
                  end
                end
              end
              OP_TIMEOUT: begin
                if (mode_q == MODE_PRIMARY && cfg_i.enable &&
                    elapsed_q > {1'b0, cfg_i.timeout_limit}) begin
                  att_d = att_n;
                  if (att_n >= cfg_i.retry_limit) begin
                    tr      = try_trigger(cfg_i.enable, mode_q, cause_q, WHY_TIMEOUT);
                    mode_d  = tr.mode;
                    cause_d = tr.cause;
                    status  = tr.status;
                    started = tr.started;
                  end
                end
              end
              OP_ICMP: begin
                cause_d = cmd_i.why;
                advises = 1'b1;
              end
              OP_MANUAL: begin
                tr      = try_trigger(cfg_i.enable, mode_q, cause_q, cmd_i.why);
                mode_d  = tr.mode;
                cause_d = tr.cause;
                status  = tr.status;
                started = tr.started;
              end
              OP_CONNECT: begin
                if (mode_q == MODE_FALLING) begin
                  if (cmd_i.ok) begin
                    mode_d = MODE_BACKUP;
                    cd_d   = probe_load;
                  end else begin
                    mode_d = MODE_PRIMARY;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = (cnt_q == '0) ? 7'd0 : div_quo[6:0];
          state_d = ST_LOSS;
        end
      end
      ST_LOSS: begin
        if (res_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
          if (mode_q == MODE_PRIMARY && cfg_i.enable && avg_q >= cfg_i.loss_trigger) begin
            tr      = try_trigger(cfg_i.enable, mode_q, cause_q, WHY_LOSS);
            mode_d  = tr.mode;
            cause_d = tr.cause;
            status  = tr.status;
            started = tr.started;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (mode_d != MODE_BACKUP) begin
      cd_d = '0;
    end
    res_d.status    = status;
    res_d.started   = started;
    res_d.advises   = advises;
    res_d.recovered = recov;
    res_d.mode      = mode_d;
    res_d.cause     = cause_d;
    res_d.avg       = avg_q;
    res_d.attempts  = att_d;
    res_valid_d     = res_load ? 1'b1 : (res_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_PRIMARY;
      cause_q     <= WHY_NONE;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      pos_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      att_q       <= '0;
      elapsed_q   <= '0;
      cd_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cause_q     <= cause_d;
      ring_q      <= ring_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      avg_q       <= avg_d;
      att_q       <= att_d;
      elapsed_q   <= elapsed_d;
      cd_q        <= cd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  ap_probe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_BACKUP) |-> (cd_q == '0))
    else $error("Probe countdown is running outside backup mode.");

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RING_DEPTH))
    else $error("Nonzero sample count exceeds the ring depth.");

  ap_started_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_d.started) |-> (res_d.mode == MODE_FALLING))
    else $error("Fallback start reported without falling back mode.");

  ap_div_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |=> (state_q == ST_LOSS))
    else $error("Average update did not move to the loss decision.");
`endif

endmodule

`default_nettype wire

// ----- design/tfc_regs.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller registers
// APB register file holding the fallback policy settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tfc_pkg::DATA_W-1:0] pwdata,
  output logic      [tfc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tfc_pkg::cfg_t                   cfg_o
);
  import tfc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:   cfg_d.enable         = pwdata[0];
        REG_TIMEOUT:  cfg_d.timeout_limit  = pwdata[19:0];
        REG_LOSS_TRG: cfg_d.loss_trigger   = pwdata[6:0];
        REG_PROBE:    cfg_d.probe_interval = pwdata[19:0];
        REG_RETRY:    cfg_d.retry_limit    = pwdata[7:0];
        REG_RECOVER:  cfg_d.recover_below  = pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ENABLE:   prdata = DATA_W'(cfg_q.enable);
      REG_TIMEOUT:  prdata = DATA_W'(cfg_q.timeout_limit);
      REG_LOSS_TRG: prdata = DATA_W'(cfg_q.loss_trigger);
      REG_PROBE:    prdata = DATA_W'(cfg_q.probe_interval);
      REG_RETRY:    prdata = DATA_W'(cfg_q.retry_limit);
      REG_RECOVER:  prdata = DATA_W'(cfg_q.recover_below);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= RST_ENABLE;
      cfg_q.timeout_limit  <= RST_TIMEOUT;
      cfg_q.loss_trigger   <= RST_LOSS_TRG;
      cfg_q.probe_interval <= RST_PROBE;
      cfg_q.retry_limit    <= RST_RETRY;
      cfg_q.recover_below  <= RST_RECOVER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/transport_fallback_controller.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller
// Per-connection primary/backup transport mode controller driven by events.
// ----------------------------------------------------------------------------
//   Channel    Handshake                  Contents
//   request    push_i / full_o            req_type, loss rate, icmp fields, reason, connect_ok
//   result     empty_o / pop_i            status, flags, mode, cause, average, attempts
//   registers  APB psel/penable/pready    six policy registers at 4*index
//
// A request that is not a loss sample passes through the command queue and the result
// register, and such requests stream at one per cycle while results are popped.
// A loss sample waits on the serial divider, which updates the average one quotient
// bit per cycle; the back end takes one request at a time.
// A two-entry command queue between front and back absorbs short stalls.
// Reset is asynchronous and active low; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none

module transport_fallback_controller (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [2:0]                 req_type_i,
  input  wire logic [6:0]                 loss_rate_i,
  input  wire logic [7:0]                 icmp_type_i,
  input  wire logic [7:0]                 icmp_code_i,
  input  wire logic [2:0]                 trigger_reason_i,
  input  wire logic                       connect_ok_i,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [1:0]                      status_o,
  output logic                            fallback_started_o,
  output logic                            icmp_advises_o,
  output logic                            recovered_o,
  output logic [1:0]                      mode_o,
  output logic [2:0]                      cause_o,
  output logic [6:0]                      average_loss_o,
  output logic [7:0]                      attempt_count_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tfc_pkg::DATA_W-1:0] pwdata,
  output logic      [tfc_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import tfc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic cmd_pop;
  logic res_valid;

  tfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .req_type_i       (req_type_i),
    .loss_rate_i      (loss_rate_i),
    .icmp_type_i      (icmp_type_i),
    .icmp_code_i      (icmp_code_i),
    .trigger_reason_i (trigger_reason_i),
    .connect_ok_i     (connect_ok_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  tfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pop_i       (pop_i)
  );

  assign empty_o            = !res_valid;
  assign status_o           = res.status;
  assign fallback_started_o = res.started;
  assign icmp_advises_o     = res.advises;
  assign recovered_o        = res.recovered;
  assign mode_o             = res.mode;
  assign cause_o            = res.cause;
  assign average_loss_o     = res.avg;
  assign attempt_count_o    = res.attempts;

endmodule

`default_nettype wire

// ----- dv/tb_transport_fallback_controller.sv -----
// ----------------------------------------------------------------------------
// Transport fallback controller testbench
// Sends event requests through the push/full queue interface and programs the
// policy registers over APB while the block is idle. A scoreboard tracks mode,
// stored cause, the loss ring, attempts and the probe countdown, works out the
// response to every accepted request, and compares each popped response with
// the oldest one it predicted. A directed opening is followed by random phases
// under several register settings, with random stalls on both sides in all but the last third.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_transport_fallback_controller;
  import tfc_pkg::*;

  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam logic [2:0] WHY_MANUAL = 3'd5;
  localparam logic [2:0] WHY_MTU    = 3'd6;
  localparam logic [2:0] WHY_SEVEN  = 3'd7;
  localparam logic [7:0] ICMP_NET_UNREACH = 8'd0;
  localparam int PHASE_ITEMS = 200;
  localparam int RAND_THIRD  = 400;
  localparam int STALL_LIMIT = 5000;

  class fallback_scoreboard;
    cfg_t        cfg;
    logic [1:0]  mode;
    logic [2:0]  cause;
    logic [6:0]  ring [RING_DEPTH];
    int unsigned pos;
    logic [7:0]  attempts;
    logic [20:0] elapsed;
    logic [19:0] countdown;
    res_t        due_results [$];
    int unsigned faults;

    function new();
      cfg = '{enable: RST_ENABLE, timeout_limit: RST_TIMEOUT, loss_trigger: RST_LOSS_TRG,
              probe_interval: RST_PROBE, retry_limit: RST_RETRY, recover_below: RST_RECOVER};
      mode = MODE_PRIMARY;
      cause = WHY_NONE;
      foreach (ring[i]) ring[i] = '0;
      pos = 0;
      attempts = '0;
      elapsed = '0;
      countdown = '0;
      faults = 0;
    endfunction

    function void set_cfg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ENABLE:   cfg.enable = val[0];
        REG_TIMEOUT:  cfg.timeout_limit = val[19:0];
        REG_LOSS_TRG: cfg.loss_trigger = val[6:0];
        REG_PROBE:    cfg.probe_interval = val[19:0];
        REG_RETRY:    cfg.retry_limit = val[7:0];
        REG_RECOVER:  cfg.recover_below = val[6:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] mean_loss();
      int unsigned sum, n;
      sum = 0;
      n = 0;
      foreach (ring[i]) begin
        if (ring[i] != 0) begin
          sum += ring[i];
          n++;
        end
      end
      return (n != 0) ? 7'(sum / n) : 7'd0;
    endfunction

    function logic [19:0] reload();
      return (cfg.probe_interval != 0) ? cfg.probe_interval : 20'd1;
    endfunction

    function logic [1:0] attempt_fallback(input logic [2:0] why, output logic started);
      started = 1'b0;
      if (!cfg.enable) return STS_DISABLED;
      if (mode == MODE_FALLING || mode == MODE_BACKUP) return STS_BUSY;
      mode = MODE_FALLING;
      cause = why;
      started = 1'b1;
      return STS_OK;
    endfunction

    function void note_request(logic [2:0] req, logic [6:0] loss, logic [7:0] ity,
                               logic [7:0] icode, logic [2:0] why, logic ok);
      res_t r;
      logic s;
      r = '0;
      s = 1'b0;
      case (req)
        REQ_TICK: begin
          if (elapsed < ELAPSED_MAX) elapsed++;
          if (mode == MODE_BACKUP && countdown != 0) begin
            countdown--;
            if (countdown == 0) begin
              if (mean_loss() < cfg.recover_below) begin
                mode = MODE_PRIMARY;
                cause = WHY_NONE;
                r.recovered = 1'b1;
              end else begin
                countdown = reload();
              end
            end
          end
        end
        REQ_TIMEOUT: begin
          if (mode == MODE_PRIMARY && cfg.enable && elapsed > cfg.timeout_limit) begin
            if (attempts < 8'd255) attempts++;
            if (attempts >= cfg.retry_limit) r.status = attempt_fallback(WHY_TIMEOUT, s);
          end
        end
        REQ_LOSS: begin
          ring[pos % RING_DEPTH] = loss;
          pos = (pos + 1) % RING_DEPTH;
          if (mode == MODE_PRIMARY && cfg.enable && mean_loss() >= cfg.loss_trigger)
            r.status = attempt_fallback(WHY_LOSS, s);
        end
        REQ_ICMP: begin
          if (ity == ICMP_UNREACH_TYPE) begin
            if (icode == ICMP_PORT_CODE) begin
              cause = WHY_UNREACH;
              r.advises = 1'b1;
            end else if (icode == ICMP_NET_PROHIB || icode == ICMP_HOST_PROHIB ||
                         icode == ICMP_ADMIN_PROHIB) begin
              cause = WHY_PROHIBITED;
              r.advises = 1'b1;
            end
          end
        end
        REQ_MANUAL: r.status = attempt_fallback(why, s);
        REQ_CONNECT: begin
          if (mode == MODE_FALLING) begin
            if (ok) begin
              mode = MODE_BACKUP;
              countdown = reload();
            end else begin
              mode = MODE_PRIMARY;
            end
          end
        end
        default: ;
      endcase
      if (mode != MODE_BACKUP) countdown = '0;
      r.started = s;
      r.mode = mode;
      r.cause = cause;
      r.avg = mean_loss();
      r.attempts = attempts;
      due_results.push_back(r);
    endfunction

    function void flag(string msg);
      if (faults < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
      faults++;
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected response %p", got));
        return;
      end
      exp = due_results.pop_front();
      if (got.status !== exp.status || got.started !== exp.started ||
          got.advises !== exp.advises || got.recovered !== exp.recovered ||
          got.mode !== exp.mode || got.cause !== exp.cause ||
          got.avg !== exp.avg || got.attempts !== exp.attempts)
        flag($sformatf("expected %p, got %p", exp, got));
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              push_i = 1'b0;
  logic              full_o;
  logic [2:0]        req_type_i = '0;
  logic [6:0]        loss_rate_i = '0;
  logic [7:0]        icmp_type_i = '0;
  logic [7:0]        icmp_code_i = '0;
  logic [2:0]        trigger_reason_i = '0;
  logic              connect_ok_i = 1'b0;
  logic              empty_o;
  logic              pop_i = 1'b0;
  logic [1:0]        status_o;
  logic              fallback_started_o;
  logic              icmp_advises_o;
  logic              recovered_o;
  logic [1:0]        mode_o;
  logic [2:0]        cause_o;
  logic [6:0]        average_loss_o;
  logic [7:0]        attempt_count_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fallback_scoreboard sb = new();
  int unsigned tx_idle = 23;
  int unsigned rx_idle = 77;
  int unsigned rand_done = 0;
  int unsigned stall_cycles = 0;

  transport_fallback_controller u_top (
    .clk_i, .rst_ni, .push_i, .full_o, .req_type_i, .loss_rate_i, .icmp_type_i,
    .icmp_code_i, .trigger_reason_i, .connect_ok_i, .empty_o, .pop_i, .status_o,
    .fallback_started_o, .icmp_advises_o, .recovered_o, .mode_o, .cause_o,
    .average_loss_o, .attempt_count_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o)
        sb.check_result({status_o, fallback_started_o, icmp_advises_o, recovered_o,
                         mode_o, cause_o, average_loss_o, attempt_count_o});
      pop_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [31:0] reg_mask(logic [2:0] idx);
    case (idx)
      REG_ENABLE:               return 32'h1;
      REG_TIMEOUT, REG_PROBE:   return 32'hF_FFFF;
      REG_LOSS_TRG, REG_RECOVER: return 32'h7F;
      REG_RETRY:                return 32'hFF;
      default:                  return 32'h0;
    endcase
  endfunction

  task automatic send_request(logic [2:0] req, logic [6:0] loss, logic [7:0] ity,
                              logic [7:0] icode, logic [2:0] why, logic ok);
    while ($urandom_range(99) < tx_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    req_type_i <= req;
    loss_rate_i <= loss;
    icmp_type_i <= ity;
    icmp_code_i <= icode;
    trigger_reason_i <= why;
    connect_ok_i <= ok;
    do @(posedge clk_i); while (full_o);
    sb.note_request(req, loss, ity, icode, why, ok);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_cfg(idx, val);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (val & reg_mask(idx)))
      sb.flag($sformatf("register %0d read %h, expected %h", idx, prdata, val & reg_mask(idx)));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_request(int unsigned tmo_w);
    logic [2:0] req;
    logic [6:0] loss;
    logic [7:0] ity, icode;
    int unsigned w;
    w = $urandom_range(99);
    if (sb.mode == MODE_FALLING && $urandom_range(1)) req = REQ_CONNECT;
    else if (w < tmo_w) req = REQ_TIMEOUT;
    else begin
      w = $urandom_range(99);
      if (w < 42) req = REQ_TICK;
      else if (w < 62) req = REQ_LOSS;
      else if (w < 72) req = REQ_ICMP;
      else if (w < 82) req = REQ_MANUAL;
      else if (w < 96) req = REQ_CONNECT;
      else req = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
    end
    w = $urandom_range(99);
    if (w < 40) loss = '0;
    else if (w < 55) loss = 7'($urandom_range(1, 9));
    else if (w < 95) loss = 7'($urandom_range(0, 100));
    else loss = 7'($urandom_range(101, 127));
    ity = ($urandom_range(99) < 70) ? ICMP_UNREACH_TYPE : 8'($urandom_range(255));
    case ($urandom_range(9))
      0: icode = ICMP_PORT_CODE;
      1: icode = ICMP_NET_PROHIB;
      2: icode = ICMP_HOST_PROHIB;
      3: icode = ICMP_ADMIN_PROHIB;
      4, 5: icode = ICMP_PORT_CODE;
      default: icode = 8'($urandom_range(255));
    endcase
    send_request(req, loss, ity, icode, 3'($urandom_range(7)),
                 ($urandom_range(99) < 80));
  endtask

  task automatic run_phase(logic en, logic [19:0] tmo, logic [6:0] trg, logic [19:0] probe,
                           logic [7:0] retry, logic [6:0] rec, int unsigned tmo_w);
    wait_drained();
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_TIMEOUT, 32'(tmo));
    write_reg(REG_LOSS_TRG, 32'(trg));
    write_reg(REG_PROBE, 32'(probe));
    write_reg(REG_RETRY, 32'(retry));
    write_reg(REG_RECOVER, 32'(rec));
    repeat (PHASE_ITEMS) begin
      if (rand_done < RAND_THIRD) begin
        tx_idle = 23;
        rx_idle = 77;
      end else if (rand_done < 2 * RAND_THIRD) begin
        tx_idle = 77;
        rx_idle = 23;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      random_request(tmo_w);
      rand_done++;
    end
    push_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_TICK, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_TIMEOUT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_LOSS, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_LOSS, 7'd127, 8'hFF, 8'hFF, WHY_SEVEN, 1'b1);
    send_request(REQ_MANUAL, 7'd0, 8'd0, 8'd0, WHY_MANUAL, 1'b0);
    send_request(REQ_CONNECT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_CONNECT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b1);
    send_request(REQ_ICMP, 7'd0, ICMP_UNREACH_TYPE, ICMP_PORT_CODE, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, ICMP_UNREACH_TYPE, ICMP_NET_PROHIB, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, ICMP_UNREACH_TYPE, ICMP_HOST_PROHIB, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, ICMP_UNREACH_TYPE, ICMP_ADMIN_PROHIB, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, ICMP_UNREACH_TYPE, ICMP_NET_UNREACH, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, 8'hFF, 8'hFF, WHY_NONE, 1'b0);
    send_request(REQ_ICMP, 7'd0, ICMP_NET_UNREACH, ICMP_PORT_CODE, WHY_NONE, 1'b0);
    send_request(REQ_MANUAL, 7'd0, 8'd0, 8'd0, WHY_SEVEN, 1'b0);
    send_request(REQ_CONNECT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b1);
    send_request(REQ_TICK, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_LOSS, 7'd100, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_MANUAL, 7'd0, 8'd0, 8'd0, WHY_MTU, 1'b0);
    send_request(REQ_SPARE6, 7'h7F, 8'hFF, 8'hFF, WHY_SEVEN, 1'b1);
    send_request(REQ_SPARE7, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_CONNECT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_LOSS, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    send_request(REQ_TIMEOUT, 7'd0, 8'd0, 8'd0, WHY_NONE, 1'b0);
    push_i <= 1'b0;

    run_phase(1'b1, 20'd10, 7'd50, 20'd5, 8'd3, 7'd10, 15);
    run_phase(1'b1, 20'd1, 7'd1, 20'd1, 8'd0, 7'd100, 15);
    run_phase(1'b0, 20'd20, 7'd30, 20'd3, 8'd2, 7'd20, 15);
    run_phase(1'b1, 20'hF_FFFF, 7'd100, 20'hF_FFFF, 8'd255, 7'd0, 15);
    run_phase(1'b1, 20'd3, 7'd60, 20'd0, 8'd1, 7'd50, 15);
    run_phase(1'b1, 20'd2, 7'd40, 20'd7, 8'd255, 7'd30, 55);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
